/* design/srp_pkg.sv */
// Shared types and constants for the sequential read prefetcher.
package srp_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PREFETCH_ENABLE = 3'd0,
    CFG_PAGE_SHIFT      = 3'd1,
    CFG_TRIGGER_HITS    = 3'd2,
    CFG_TRIGGER_PAGES   = 3'd3,
    CFG_PREFETCH_PAGES  = 3'd4
  } cfg_idx_e;

  // Configuration register file.
  typedef struct packed {
    logic        prefetch_enable;
    logic [4:0]  page_shift;
    logic [15:0] trigger_hits;
    logic [31:0] trigger_pages;
    logic [12:0] prefetch_pages;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prefetch_enable: 1'b1,
    page_shift:      5'd12,
    trigger_hits:    16'd4,
    trigger_pages:   32'd64,
    prefetch_pages:  13'd32
  };

  // Legal page shift range and burst size limit.
  localparam logic [4:0]  SHIFT_MIN   = 5'd9;
  localparam logic [4:0]  SHIFT_MAX   = 5'd16;
  localparam logic [12:0] BURST_MAX   = 13'd4096;

  // Page numbers of prefetch bursts are 33 bits wide and saturate.
  localparam logic [32:0] PAGE33_MAX  = 33'h1_FFFF_FFFF;

endpackage

/* design/sequential_read_prefetcher.sv */
// Sequential read stream detector and prefetch issuer, top level.
// Path: an accepted item passes the input register and then the result register.
// Throughput: one item per cycle unless the receiver stalls; the detector state is updated in the
// same cycle an item moves into the result register, so the next item always sees it.
// Reset: detector state clears (last tag reads 1, trigger page all ones) and the configuration
// registers return to their defaults; no clearing pass is needed.
module sequential_read_prefetcher #(
  parameter int PAGE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Request items.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] request_tag_i,
  input  logic [31:0] page_number_i,
  input  logic [15:0] skip_bytes_i,
  input  logic [16:0] byte_length_i,
  input  logic        internal_request_i,
  // Result items.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        prefetch_issue_o,
  output logic        prefetch_kind_o,
  output logic [32:0] prefetch_start_o,
  output logic [12:0] prefetch_count_o,
  output logic        sequential_mode_o
);
  import srp_pkg::*;

  // FW holds a byte address with no overflow; byte addresses are kept modulo 2^64.
  localparam int FW = PAGE_BITS + 17;
  localparam int AW = (FW > 64) ? 64 : FW;
  // Width that holds page_number + 1 and the 33-bit saturation limit.
  localparam int NW = (PAGE_BITS + 1 > 34) ? PAGE_BITS + 1 : 34;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must only be made while the block is idle;
  // the block does not enforce this, and the port is always ready.
  // ---------------------------------------------------------------------------
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PREFETCH_ENABLE: cfg_d.prefetch_enable = cfg_data_i[0];
        CFG_PAGE_SHIFT:      cfg_d.page_shift      = cfg_data_i[4:0];
        CFG_TRIGGER_HITS:    cfg_d.trigger_hits    = cfg_data_i[15:0];
        CFG_TRIGGER_PAGES:   cfg_d.trigger_pages   = cfg_data_i;
        CFG_PREFETCH_PAGES:  cfg_d.prefetch_pages  = cfg_data_i[12:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Out-of-range settings are clamped to the nearest legal value.
  logic [4:0]  eff_shift;
  logic [12:0] eff_count;

  always_comb begin
    if (cfg_q.page_shift < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (cfg_q.page_shift > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = cfg_q.page_shift;
    end
    if (cfg_q.prefetch_pages == 13'd0) begin
      eff_count = 13'd1;
    end else if (cfg_q.prefetch_pages > BURST_MAX) begin
      eff_count = BURST_MAX;
    end else begin
      eff_count = cfg_q.prefetch_pages;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The input register moves whenever the result register is empty
  // or is being emptied, so one item can pass every cycle.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv, in_fire, s1_fire;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_fire    = s1_valid_q && s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Input register. The byte start, byte end and next page of the item are
  // worked out here, since they need only the item and the page shift.
  // ---------------------------------------------------------------------------
  logic [PAGE_BITS-1:0] page_p;
  logic [FW-1:0]        start_full, end_full;
  logic [NW-1:0]        nextp_full;
  logic [32:0]          nextp_sat;

  assign page_p     = PAGE_BITS'(page_number_i);
  assign start_full = (FW'(page_p) << eff_shift) + FW'(skip_bytes_i);
  assign end_full   = start_full + FW'(byte_length_i);
  assign nextp_full = NW'(page_p) + NW'(1);
  assign nextp_sat  = (nextp_full > NW'(PAGE33_MAX)) ? PAGE33_MAX : nextp_full[32:0];

  logic [31:0]   s1_tag_q;
  logic [AW-1:0] s1_start_q, s1_end_q;
  logic [32:0]   s1_nextp_q;
  logic          s1_internal_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_tag_q      <= request_tag_i;
      s1_start_q    <= start_full[AW-1:0];
      s1_end_q      <= end_full[AW-1:0];
      s1_nextp_q    <= nextp_sat;
      s1_internal_q <= internal_request_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Detector state. The previous request is kept as its end address.
  // ---------------------------------------------------------------------------
  logic [31:0]   last_tag_q, last_tag_d;
  logic [AW-1:0] prev_end_q, prev_end_d;
  logic          prev_valid_q, prev_valid_d;
  logic [31:0]   hit_count_q, hit_count_d;
  logic [63:0]   byte_sum_q, byte_sum_d;
  logic          seq_q, seq_d;
  logic [32:0]   trig_page_q, trig_page_d;
  logic [32:0]   next_pf_q, next_pf_d;

  // Result of the current item.
  logic        res_issue, res_kind;
  logic [32:0] res_start;
  logic [12:0] res_count;
  logic        res_seq;

  logic        active;
  logic [64:0] sum_wide;
  logic [63:0] sum_sat;
  logic [31:0] hit_inc;
  logic        pf_go;
  logic [32:0] pf_begin;
  logic [33:0] trig_wide, next_wide;

  assign active    = cfg_q.prefetch_enable && !s1_internal_q;
  assign sum_wide  = {1'b0, byte_sum_q} + 65'(prev_end_q);
  assign sum_sat   = sum_wide[64] ? '1 : sum_wide[63:0];
  assign hit_inc   = (hit_count_q == '1) ? hit_count_q : hit_count_q + 32'd1;

  // A read-ahead starts just past the current page; a continued prefetch
  // picks up where the last burst ended, once the stream passes the trigger.
  assign pf_go     = !seq_q || (s1_nextp_q >= trig_page_q);
  assign pf_begin  = seq_q ? next_pf_q : s1_nextp_q;
  assign trig_wide = {1'b0, pf_begin} + 34'(eff_count[12:1]);
  assign next_wide = {1'b0, pf_begin} + 34'(eff_count);

  always_comb begin
    last_tag_d   = last_tag_q;
    prev_end_d   = prev_end_q;
    prev_valid_d = prev_valid_q;
    hit_count_d  = hit_count_q;
    byte_sum_d   = byte_sum_q;
    seq_d        = seq_q;
    trig_page_d  = trig_page_q;
    next_pf_d    = next_pf_q;
    res_issue    = 1'b0;
    res_kind     = 1'b0;
    res_start    = '0;
    res_count    = '0;

    if (active) begin
      if (s1_tag_q != last_tag_q) begin
        if (prev_valid_q && (prev_end_q == s1_start_q)) begin
          // Contiguous with the previous request: count it until sequential.
          if (!seq_q) begin
            hit_count_d = hit_inc;
            byte_sum_d  = sum_sat;
            if ((hit_inc >= 32'(cfg_q.trigger_hits)) &&
                ((sum_sat >> eff_shift) >= 64'(cfg_q.trigger_pages))) begin
              seq_d = 1'b1;
            end
          end
        end else begin
          seq_d       = 1'b0;
          hit_count_d = '0;
          byte_sum_d  = '0;
        end
        last_tag_d = s1_tag_q;
      end
      prev_end_d   = s1_end_q;
      prev_valid_d = 1'b1;

      if (seq_d && pf_go) begin
        res_issue   = 1'b1;
        res_kind    = seq_q;
        res_start   = pf_begin;
        res_count   = eff_count;
        trig_page_d = trig_wide[33] ? PAGE33_MAX : trig_wide[32:0];
        next_pf_d   = next_wide[33] ? PAGE33_MAX : next_wide[32:0];
      end
    end

    res_seq = cfg_q.prefetch_enable && seq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tag_q   <= 32'd1;
      prev_end_q   <= '0;
      prev_valid_q <= 1'b0;
      hit_count_q  <= '0;
      byte_sum_q   <= '0;
      seq_q        <= 1'b0;
      trig_page_q  <= PAGE33_MAX;
      next_pf_q    <= '0;
    end else if (s1_fire) begin
      last_tag_q   <= last_tag_d;
      prev_end_q   <= prev_end_d;
      prev_valid_q <= prev_valid_d;
      hit_count_q  <= hit_count_d;
      byte_sum_q   <= byte_sum_d;
      seq_q        <= seq_d;
      trig_page_q  <= trig_page_d;
      next_pf_q    <= next_pf_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      prefetch_issue_o  <= res_issue;
      prefetch_kind_o   <= res_kind;
      prefetch_start_o  <= res_start;
      prefetch_count_o  <= res_count;
      sequential_mode_o <= res_seq;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // An issued burst always has pages and is only issued in sequential mode.
  a_issue_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && prefetch_issue_o) |-> (prefetch_count_o != 13'd0) && sequential_mode_o)
    else $error("issued burst without pages or outside sequential mode");

  // With no burst the start, count and kind fields are all zero.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !prefetch_issue_o) |->
      (prefetch_start_o == 33'd0) && (prefetch_count_o == 13'd0) && !prefetch_kind_o)
    else $error("result fields set without a burst");

  // The input only stalls while both registers hold items and the receiver is not ready.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // Leaving sequential mode clears the hit count and byte sum.
  a_seq_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(seq_q) |-> (hit_count_q == 32'd0) && (byte_sum_q == 64'd0))
    else $error("sequential mode left without clearing the detector");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sequential read prefetcher.
module tb;
  import srp_pkg::*;

  // An accepted item passes the input register and then the result register.
  localparam int RESULT_LATENCY = 2;
  localparam int PHASE_ITEMS    = 56;
  // Cycles that the receiver holds off once to fill the block up.
  localparam int HOLD_CYCLES    = 200;

  // One result item of the block.
  typedef struct packed {
    logic        issue;
    logic        kind;
    logic [32:0] first_page;
    logic [12:0] pages;
    logic        seq;
  } burst_t;

  // One directed request; typed marks rows whose result is written out by hand.
  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] page;
    logic [15:0] skip;
    logic [16:0] len;
    logic        intl;
    logic        typed;
    burst_t      want;
  } req_row_t;

  // Directed requests under the reset configuration (4 KiB pages, four hits, 64 pages,
  // bursts of 32). The first real request has no previous one, so its zero start must not
  // count as a hit; the next four contiguous requests then enter sequential mode.
  localparam req_row_t DIRECTED [20] = '{
    // Internal request right after reset: state untouched, nothing issued.
    '{32'd5, 32'd0, 16'd0, 17'd0, 1'b1, 1'b1, '0},
    // No previous request: a tag change is a miss even though the start matches zero.
    '{32'd2, 32'd0, 16'd0, 17'h10000, 1'b0, 1'b1, '0},
    '{32'd3, 32'd16, 16'd0, 17'h10000, 1'b0, 1'b0, '0},
    '{32'd4, 32'd32, 16'd0, 17'h10000, 1'b0, 1'b0, '0},
    '{32'd5, 32'd48, 16'd0, 17'h10000, 1'b0, 1'b0, '0},
    // Fourth hit enters sequential mode and reads ahead from the next page.
    '{32'd6, 32'd64, 16'd0, 17'h10000, 1'b0, 1'b1, '{1'b1, 1'b0, 33'd65, 13'd32, 1'b1}},
    // Same tag: no contiguity check, the previous extent moves; the trigger page is reached.
    '{32'd6, 32'd80, 16'd0, 17'h10000, 1'b0, 1'b0, '0},
    '{32'd7, 32'd96, 16'd0, 17'h10000, 1'b0, 1'b0, '0},
    // Internal request while sequential: mode is still reported.
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h10000, 1'b1, 1'b1,
      '{1'b0, 1'b0, 33'd0, 13'd0, 1'b1}},
    '{32'd8, 32'd112, 16'd0, 17'h10000, 1'b0, 1'b0, '0},
    // A jump clears the detector.
    '{32'd9, 32'd500, 16'd0, 17'h10000, 1'b0, 1'b1, '0},
    '{32'd9, 32'hFFFF_FFFF, 16'hFFFF, 17'h10000, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'd0, 16'd0, 17'd0, 1'b0, 1'b0, '0},
    // Zero-length requests at address zero still count as contiguous.
    '{32'd0, 32'd0, 16'd0, 17'd0, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'd0, 16'd0, 17'd1, 1'b0, 1'b0, '0},
    '{32'd0, 32'd0, 16'd1, 17'h10000, 1'b0, 1'b0, '0},
    // Enough hits, but the byte sum stays below the page threshold.
    '{32'h5555_5555, 32'd16, 16'd1, 17'd0, 1'b0, 1'b0, '0},
    '{32'hAAAA_AAAA, 32'd16, 16'd1, 17'd0, 1'b0, 1'b0, '0},
    '{32'h1234_5678, 32'hAAAA_AAAA, 16'hAAAA, 17'h0AAAA, 1'b0, 1'b0, '0},
    '{32'h8765_4321, 32'h5555_5555, 16'h5555, 17'h05555, 1'b0, 1'b0, '0}
  };

  // Register settings of the random phases, extremes and out-of-range values included.
  localparam cfg_t PHASES [8] = '{
    '{1'b1, 5'd9,  16'd0,      32'd0,          13'd1},
    '{1'b1, 5'd16, 16'd2,      32'd1,          13'd4096},
    '{1'b1, 5'd0,  16'd3,      32'd8,          13'd0},
    '{1'b1, 5'd31, 16'd1,      32'hFFFF_FFFF,  13'h1FFF},
    '{1'b0, 5'd12, 16'd4,      32'd64,         13'd32},
    '{1'b1, 5'd12, 16'hFFFF,   32'd0,          13'd16},
    '{1'b1, 5'd10, 16'd4,      32'd16,         13'd5},
    '{1'b1, 5'd13, 16'd2,      32'd4,          13'd8}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] req_tag = '0;
  logic [31:0] req_page = '0;
  logic [15:0] req_skip = '0;
  logic [16:0] req_len = '0;
  logic        req_intl = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  burst_t      dut_burst;

  // Shadow of the configuration registers and the detector state.
  cfg_t        live_cfg = CFG_RESET;
  logic [31:0] last_tag_q = 32'd1;
  logic [63:0] prev_off_q = '0;
  logic [16:0] prev_len_q = '0;
  logic        prev_valid_q = 1'b0;
  logic [31:0] hits_q = '0;
  logic [63:0] sum_q = '0;
  logic        seq_q = 1'b0;
  logic [32:0] trig_page_q = PAGE33_MAX;
  logic [32:0] next_pf_q = '0;

  burst_t      predicted_bursts[$];
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned read_aheads = 0;
  int unsigned continued = 0;
  int unsigned seq_results = 0;
  bit          held_off = 1'b0;

  always #2 clk = ~clk;

  sequential_read_prefetcher u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .request_tag_i      (req_tag),
    .page_number_i      (req_page),
    .skip_bytes_i       (req_skip),
    .byte_length_i      (req_len),
    .internal_request_i (req_intl),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .prefetch_issue_o   (dut_burst.issue),
    .prefetch_kind_o    (dut_burst.kind),
    .prefetch_start_o   (dut_burst.first_page),
    .prefetch_count_o   (dut_burst.pages),
    .sequential_mode_o  (dut_burst.seq)
  );

  // Page shift as the block uses it: the register is clamped to the legal range.
  function automatic logic [4:0] page_shift_eff();
    if (live_cfg.page_shift < SHIFT_MIN) return SHIFT_MIN;
    if (live_cfg.page_shift > SHIFT_MAX) return SHIFT_MAX;
    return live_cfg.page_shift;
  endfunction

  function automatic logic [32:0] sat33(input logic [33:0] v);
    return v[33] ? PAGE33_MAX : v[32:0];
  endfunction

  // Runs the stream detector on one request and returns the burst it issues.
  function automatic burst_t predict_burst(input logic [31:0] tag, input logic [31:0] page,
                                           input logic [15:0] skip, input logic [16:0] len,
                                           input logic intl);
    burst_t      res;
    logic [4:0]  sh;
    logic [63:0] start_byte;
    logic [63:0] prev_end;
    logic [32:0] next_page;
    logic [32:0] first;
    logic [12:0] cnt;
    logic        was_seq;
    res = '0;
    sh = page_shift_eff();
    if (live_cfg.prefetch_enable && !intl) begin
      was_seq = seq_q;
      start_byte = ({32'd0, page} << sh) + {48'd0, skip};
      // The contiguity check runs only when a new host request begins.
      if (tag != last_tag_q) begin
        prev_end = prev_off_q + {47'd0, prev_len_q};
        if (prev_valid_q && prev_end == start_byte) begin
          if (!seq_q) begin
            if (hits_q != 32'hFFFF_FFFF) hits_q++;
            if (sum_q > ~64'd0 - prev_end) sum_q = ~64'd0;
            else sum_q += prev_end;
            if (hits_q >= {16'd0, live_cfg.trigger_hits} &&
                (sum_q >> sh) >= {32'd0, live_cfg.trigger_pages}) seq_q = 1'b1;
          end
        end else begin
          seq_q = 1'b0;
          hits_q = '0;
          sum_q = '0;
        end
        last_tag_q = tag;
      end
      prev_off_q = start_byte;
      prev_len_q = len;
      prev_valid_q = 1'b1;
      if (seq_q) begin
        next_page = {1'b0, page} + 33'd1;
        if (live_cfg.prefetch_pages == 13'd0) cnt = 13'd1;
        else if (live_cfg.prefetch_pages > BURST_MAX) cnt = BURST_MAX;
        else cnt = live_cfg.prefetch_pages;
        // The first sequential item reads ahead; later ones wait for the trigger page.
        if (!was_seq || next_page >= trig_page_q) begin
          first = was_seq ? next_pf_q : next_page;
          res.issue = 1'b1;
          res.kind = was_seq;
          res.first_page = first;
          res.pages = cnt;
          trig_page_q = sat33({1'b0, first} + {21'd0, cnt >> 1});
          next_pf_q = sat33({1'b0, first} + {21'd0, cnt});
        end
      end
    end
    res.seq = live_cfg.prefetch_enable && seq_q;
    return res;
  endfunction

  // Offers one request in bursts with random gaps and queues the burst it should cause.
  task automatic offer_request(input logic [31:0] tag, input logic [31:0] page,
                               input logic [15:0] skip, input logic [16:0] len,
                               input logic intl, input logic typed, input burst_t typed_burst);
    burst_t      predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      // Now and then a long burst, so that stretches without gaps occur.
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    req_tag <= tag;
    req_page <= page;
    req_skip <= skip;
    req_len <= len;
    req_intl <= intl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Accepted at this edge; the predictor must still run to keep its state in step.
    predicted = predict_burst(tag, page, skip, len, intl);
    predicted_bursts.push_back(typed ? typed_burst : predicted);
    items_sent++;
  endtask

  // Waits until every queued burst has come out and the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (predicted_bursts.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // Writes one register; the valid stays up so that writes can follow back to back.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PREFETCH_ENABLE: live_cfg.prefetch_enable = data[0];
      CFG_PAGE_SHIFT:      live_cfg.page_shift = data[4:0];
      CFG_TRIGGER_HITS:    live_cfg.trigger_hits = data[15:0];
      CFG_TRIGGER_PAGES:   live_cfg.trigger_pages = data;
      CFG_PREFETCH_PAGES:  live_cfg.prefetch_pages = data[12:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [32:0] want,
                             input logic [32:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result monitor: every accepted result is compared with the oldest queued burst.
  always @(posedge clk) begin
    burst_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (dut_burst.issue === 1'b1) begin
        if (dut_burst.kind) continued++;
        else read_aheads++;
      end
      if (dut_burst.seq === 1'b1) seq_results++;
      if (predicted_bursts.size() == 0) begin
        $display("%0t: result with nothing expected, actual issue %0b start 0x%0h",
                 $time, dut_burst.issue, dut_burst.first_page);
        errors++;
      end else begin
        want = predicted_bursts.pop_front();
        check_field("prefetch_issue", 33'(want.issue), 33'(dut_burst.issue));
        check_field("prefetch_kind", 33'(want.kind), 33'(dut_burst.kind));
        check_field("prefetch_start", want.first_page, dut_burst.first_page);
        check_field("prefetch_count", 33'(want.pages), 33'(dut_burst.pages));
        check_field("sequential_mode", 33'(want.seq), 33'(dut_burst.seq));
      end
    end
  end

  // Receiver: a mix of open stretches, toggling, coin flips and short stalls. Once, early in
  // the first random phase, it holds off long enough for the block to stall its input while
  // the sender still has many items of that phase left to offer.
  initial begin
    int unsigned mode;
    int unsigned span;
    @(posedge rst_n);
    forever begin
      if (!held_off && items_sent >= 30) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(1, 30);
      repeat (span) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ~out_ready;
          2: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus: directed requests, then random phases under varied register settings.
  initial begin
    logic [31:0] tag;
    logic [31:0] page;
    logic [15:0] skip;
    logic [16:0] len;
    logic        intl;
    logic [31:0] cur_tag;
    logic [63:0] stream_end;
    logic [63:0] page_wide;
    logic [31:0] span;
    logic [4:0]  sh;
    int unsigned pick;
    cur_tag = '0;
    stream_end = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      offer_request(DIRECTED[i].tag, DIRECTED[i].page, DIRECTED[i].skip, DIRECTED[i].len,
                    DIRECTED[i].intl, DIRECTED[i].typed, DIRECTED[i].want);
    end

    foreach (PHASES[p]) begin
      // Registers change only while the block is empty.
      wait_idle();
      write_reg(CFG_PREFETCH_ENABLE, {31'd0, PHASES[p].prefetch_enable});
      write_reg(CFG_PAGE_SHIFT, {27'd0, PHASES[p].page_shift});
      write_reg(CFG_TRIGGER_HITS, {16'd0, PHASES[p].trigger_hits});
      write_reg(CFG_TRIGGER_PAGES, PHASES[p].trigger_pages);
      write_reg(CFG_PREFETCH_PAGES, {19'd0, PHASES[p].prefetch_pages});
      cfg_valid <= 1'b0;
      sh = page_shift_eff();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        intl = 1'b0;
        // Lengths are mostly whole pages, sometimes any byte count.
        if ($urandom_range(0, 3) == 0) begin
          len = 17'($urandom_range(0, 32'h10000));
        end else begin
          span = 32'($urandom_range(1, 8)) << sh;
          len = (span > 32'h10000) ? 17'h10000 : span[16:0];
        end
        if (pick < 8) begin
          // Internal request with random content.
          tag = $urandom;
          page = $urandom;
          skip = 16'($urandom);
          intl = 1'b1;
        end else if (pick < 16) begin
          // Noise: a new stream somewhere else, often near the top of the page range.
          tag = $urandom;
          page = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 64)
                                             : $urandom;
          skip = 16'($urandom);
        end else begin
          // Well-formed: the next sub-request of the stream, mostly under a new tag.
          tag = (pick < 30) ? cur_tag : cur_tag + $urandom_range(1, 3);
          page_wide = stream_end >> sh;
          if (page_wide[63:32] != 32'd0) begin
            page = $urandom_range(0, 1000);
            skip = '0;
          end else begin
            page = page_wide[31:0];
            skip = 16'(stream_end & ((64'd1 << sh) - 64'd1));
          end
        end
        if (!intl) begin
          cur_tag = tag;
          stream_end = ({32'd0, page} << sh) + {48'd0, skip} + {47'd0, len};
        end
        offer_request(tag, page, skip, len, intl, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests through %0d register settings; checked %0d results.",
             items_sent, $size(PHASES) + 1, results_seen);
    $display("Seen %0d read-aheads, %0d continued prefetches, %0d sequential results.",
             read_aheads, continued, seq_results);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
